/* rtl/counting_semaphore_engine_core_macros.svh */
// Assertion macros used by the semaphore engine checker.
`ifndef COUNTING_SEMAPHORE_ENGINE_CORE_MACROS_SVH
`define COUNTING_SEMAPHORE_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CSE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("semaphore engine check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CSE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("semaphore engine check failed");

`endif

/* rtl/cse_pkg.sv */
// Shared types and constants of the counting semaphore engine.
`timescale 1ns / 1ps

package cse_pkg;

    // Transaction field widths
    localparam int CMD_W    = 2;
    localparam int SID_W    = 4;
    localparam int PID_W    = 5;
    localparam int INIT_W   = 8;
    localparam int STATUS_W = 3;
    localparam int NEWID_W  = 4;

    // Packed port widths (padded to whole bytes)
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOCK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNLOCK = 2'd2;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_PROCEED   = 3'd0,
        ST_SUSPENDED = 3'd1,
        ST_RELEASED  = 3'd2,
        ST_NO_FREE   = 3'd3,
        ST_QFULL     = 3'd4
    } status_t;

    // Wait-queue memory operation
    typedef struct packed {
        logic wr;
        logic rd;
    } mem_op_t;

endpackage

/* rtl/cse_wait_mem.sv */
// Wait-queue storage: single port RAM with registered read data.
`timescale 1ns / 1ps

module cse_wait_mem #(
    parameter int ADDR_W = 9,
    parameter int DATA_W = 5
) (
    input  logic                clk,
    input  cse_pkg::mem_op_t    op,
    input  logic [ADDR_W-1:0]   addr,
    input  logic [DATA_W-1:0]   wdata,
    output logic [DATA_W-1:0]   rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // One write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (op.wr)
        begin
            mem[addr] <= wdata;
        end
        if (op.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/counting_semaphore_engine_core.sv */
// Top level of the counting semaphore engine.
`timescale 1ns / 1ps
// Counting semaphore engine: a pool of NUM_SEMS semaphores with FIFO wait queues.
// Input channel s_axis: one transaction per kernel call, cmd in tuser
// (create, lock, unlock), semaphore id, caller pid and initial count in tdata.
// Output channel m_axis: exactly one result per call, status in tuser,
// allocated id and released pid in tdata.
// Create hands out ids 0, 1, ... in ascending order; ids are never returned.
// A call passes the input register, then the result register, which loads
// once the result side is free or being read. Throughput: one call per cycle
// while the receiver keeps up; the count, queue head and fill of a semaphore
// are read and updated combinationally and written back together, and the
// wait-queue RAM takes one access per call.
// The result register parts the two sides: a call is still taken while the
// result waits, and a stalled receiver stops the engine only once both the
// input and result registers are full; s_axis_tready then goes low.
// Reset: all counts, queue heads and fills go to zero and every id is free.
// Wait-queue RAM contents are not cleared; no clearing pass is needed and
// the block takes calls as soon as reset is released.
module counting_semaphore_engine_core #(
    parameter int NUM_SEMS   = 16,
    parameter int NUM_PROCS  = 32,
    parameter int COUNT_BITS = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [3:0] sem_id, [8:4] caller_pid, [16:9] initial_count, [23:17] zero
    input  logic [cse_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [1:0] cmd
    input  logic [cse_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [3:0] new_id, [8:4] released_pid, [15:9] zero
    output logic [cse_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // [2:0] status
    output logic [cse_pkg::STATUS_W-1:0]     m_axis_tuser
);

    localparam int SEM_W  = $clog2(NUM_SEMS);
    localparam int ALLOC_W = $clog2(NUM_SEMS + 1);
    localparam int QW     = $clog2(NUM_PROCS);
    localparam int FW     = $clog2(NUM_PROCS + 1);
    localparam int ADDR_W = SEM_W + QW;
    localparam int PID_W  = cse_pkg::PID_W;

    // Input register
    logic                        in_v_reg;
    logic [cse_pkg::CMD_W-1:0]   cmd_reg;
    logic [cse_pkg::SID_W-1:0]   sid_reg;
    logic [PID_W-1:0]            pid_reg;
    logic [cse_pkg::INIT_W-1:0]  init_reg;

    // Per-semaphore state
    logic [COUNT_BITS-1:0] count_reg [NUM_SEMS];
    logic [QW-1:0]         head_reg  [NUM_SEMS];
    logic [FW-1:0]         fill_reg  [NUM_SEMS];
    logic [ALLOC_W-1:0]    alloc_reg;
    logic [ALLOC_W-1:0]    alloc_next;

    // Result register
    logic                           out_v_reg;
    cse_pkg::status_t               status_reg;
    cse_pkg::status_t               status_next;
    logic [cse_pkg::NEWID_W-1:0]    new_id_reg;
    logic [cse_pkg::NEWID_W-1:0]    new_id_next;

    // Working signals
    logic                  load;
    logic                  sid_ok;
    logic                  free_empty;
    logic [SEM_W-1:0]      sidx;
    logic [SEM_W-1:0]      aidx;
    logic [SEM_W-1:0]      widx;
    logic [COUNT_BITS-1:0] cur_count;
    logic [QW-1:0]         cur_head;
    logic [FW-1:0]         cur_fill;
    logic [FW:0]           tail_sum;
    logic [QW-1:0]         tail_slot;
    logic [QW-1:0]         head_inc;
    logic [31:0]           init_ext;
    logic                  st_we;
    logic [COUNT_BITS-1:0] count_new;
    logic [QW-1:0]         head_new;
    logic [FW-1:0]         fill_new;
    cse_pkg::mem_op_t      mem_op;
    logic [ADDR_W-1:0]     mem_addr;
    logic [PID_W-1:0]      mem_rdata;

    // Handshake: result register parts the two sides
    assign load          = in_v_reg && (!out_v_reg || m_axis_tready);
    assign s_axis_tready = !in_v_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_v_reg <= s_axis_tvalid;
        end
    end

    // Input payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg  <= s_axis_tuser;
            sid_reg  <= s_axis_tdata[3:0];
            pid_reg  <= s_axis_tdata[8:4];
            init_reg <= s_axis_tdata[16:9];
        end
    end

    // Addressing and current state of the addressed semaphore
    assign sid_ok     = (32'(sid_reg) < 32'(NUM_SEMS));
    assign sidx       = SEM_W'(sid_reg);
    assign aidx       = SEM_W'(alloc_reg);
    assign free_empty = (alloc_reg == ALLOC_W'(NUM_SEMS));
    assign widx       = (cmd_reg == cse_pkg::CMD_CREATE) ? aidx : sidx;
    assign cur_count  = count_reg[sidx];
    assign cur_head   = head_reg[sidx];
    assign cur_fill   = fill_reg[sidx];
    assign init_ext   = 32'(init_reg);

    // Tail slot (head + fill) wrapped once, head advance wrapped
    assign tail_sum  = (FW + 1)'(cur_head) + (FW + 1)'(cur_fill);
    assign tail_slot = (tail_sum >= (FW + 1)'(NUM_PROCS))
                     ? QW'(tail_sum - (FW + 1)'(NUM_PROCS)) : QW'(tail_sum);
    assign head_inc  = (32'(cur_head) == 32'(NUM_PROCS - 1)) ? '0 : cur_head + 1'b1;

    // Command decode and state update
    always_comb
    begin
        status_next = cse_pkg::ST_PROCEED;
        new_id_next = '0;
        alloc_next  = alloc_reg;
        st_we       = 1'b0;
        count_new   = cur_count;
        head_new    = cur_head;
        fill_new    = cur_fill;
        mem_op      = '0;
        mem_addr    = {sidx, cur_head};
        case (cmd_reg)
            cse_pkg::CMD_CREATE:
            begin
                if (free_empty)
                begin
                    status_next = cse_pkg::ST_NO_FREE;
                end
                else
                begin
                    alloc_next  = alloc_reg + 1'b1;
                    st_we       = 1'b1;
                    count_new   = init_ext[COUNT_BITS-1:0];
                    head_new    = '0;
                    fill_new    = '0;
                    new_id_next = cse_pkg::NEWID_W'(alloc_reg);
                end
            end
            cse_pkg::CMD_LOCK:
            begin
                if (sid_ok)
                begin
                    if (cur_count != '0)
                    begin
                        st_we     = 1'b1;
                        count_new = cur_count - 1'b1;
                    end
                    else if (cur_fill == FW'(NUM_PROCS))
                    begin
                        status_next = cse_pkg::ST_QFULL;
                    end
                    else
                    begin
                        st_we       = 1'b1;
                        fill_new    = cur_fill + 1'b1;
                        mem_op.wr   = 1'b1;
                        mem_addr    = {sidx, tail_slot};
                        status_next = cse_pkg::ST_SUSPENDED;
                    end
                end
            end
            cse_pkg::CMD_UNLOCK:
            begin
                if (sid_ok)
                begin
                    if (cur_fill == '0)
                    begin
                        st_we = 1'b1;
                        if (cur_count != {COUNT_BITS{1'b1}})
                        begin
                            count_new = cur_count + 1'b1;
                        end
                    end
                    else
                    begin
                        st_we       = 1'b1;
                        head_new    = head_inc;
                        fill_new    = cur_fill - 1'b1;
                        mem_op.rd   = 1'b1;
                        status_next = cse_pkg::ST_RELEASED;
                    end
                end
            end
            default:
            begin
                status_next = cse_pkg::ST_PROCEED;
            end
        endcase
        if (!load)
        begin
            mem_op = '0;
        end
    end

    // Per-semaphore state and id allocator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SEMS; i++)
            begin
                count_reg[i] <= '0;
                head_reg[i]  <= '0;
                fill_reg[i]  <= '0;
            end
            alloc_reg <= '0;
        end
        else if (load)
        begin
            alloc_reg <= alloc_next;
            if (st_we)
            begin
                count_reg[widx] <= count_new;
                head_reg[widx]  <= head_new;
                fill_reg[widx]  <= fill_new;
            end
        end
    end

    // Wait-queue RAM
    cse_wait_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (PID_W)
    ) u_wait_mem (
        .clk   (clk),
        .op    (mem_op),
        .addr  (mem_addr),
        .wdata (pid_reg),
        .rdata (mem_rdata)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (load)
        begin
            out_v_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_next;
            new_id_reg <= new_id_next;
        end
    end

    // Output packing; released pid shows only on a release
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {7'b0,
                            (status_reg == cse_pkg::ST_RELEASED) ? mem_rdata : {PID_W{1'b0}},
                            new_id_reg};

endmodule

/* rtl/cse_checker.sv */
// Port-level checker for the semaphore engine, bound to the top level.
`timescale 1ns / 1ps
`include "counting_semaphore_engine_core_macros.svh"

module cse_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // Released pid is zero unless a waiter was released
    `CSE_ASSERT_IMP(a_rel_zero, m_axis_tvalid && (m_axis_tuser != cse_pkg::ST_RELEASED), m_axis_tdata[8:4] == 5'd0)

    // An allocated id appears only on a successful call
    `CSE_ASSERT_IMP(a_id_zero, m_axis_tvalid && (m_axis_tuser != cse_pkg::ST_PROCEED), m_axis_tdata[3:0] == 4'd0)

    // A result first shows once its accepted call has passed the input and result registers
    `CSE_ASSERT_IMP(a_rise_src, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2))

    // Stalled result holds
    `CSE_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind counting_semaphore_engine_core cse_checker u_cse_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* verif/counting_semaphore_engine_core_tb.sv */
// Self-checking testbench for the counting semaphore engine core.
`timescale 1ns / 1ps

module counting_semaphore_engine_core_tb;
    import cse_pkg::*;

    localparam int NUM_SEMS     = 16;
    localparam int NUM_PROCS    = 32;
    localparam int COUNT_BITS   = 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 8;

    // One result transaction as the engine should answer it
    typedef struct packed {
        status_t              status;
        logic [NEWID_W-1:0]   new_id;
        logic [PID_W-1:0]     released_pid;
    } sem_result_t;

    // Shadow copy of the semaphore pool plus the queue of pending answers
    class sem_scoreboard;
        logic [COUNT_BITS-1:0] sem_count [NUM_SEMS];
        logic [PID_W-1:0]      waiters [NUM_SEMS][NUM_PROCS];
        int                    wait_head [NUM_SEMS];
        int                    wait_fill [NUM_SEMS];
        logic [SID_W-1:0]      free_ids [NUM_SEMS];
        int                    free_head;
        int                    free_fill;
        sem_result_t           pending_answers [$];
        int                    errors;
        int                    calls;
        int                    checked;
        int                    status_seen [5];

        function new();
            for (int i = 0; i < NUM_SEMS; i++)
            begin
                sem_count[i] = '0;
                wait_head[i] = 0;
                wait_fill[i] = 0;
                free_ids[i]  = SID_W'(i);
            end
            free_head = 0;
            free_fill = NUM_SEMS;
            errors    = 0;
            calls     = 0;
            checked   = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // Apply an accepted call to the shadow pool and queue its answer
        function void note_call(logic [CMD_W-1:0] cmd, logic [SID_W-1:0] sid,
                                logic [PID_W-1:0] pid, logic [INIT_W-1:0] init);
            sem_result_t r;
            int          id;
            int          slot;
            r.status       = ST_PROCEED;
            r.new_id       = '0;
            r.released_pid = '0;
            calls++;
            case (cmd)
                CMD_CREATE:
                begin
                    if (free_fill == 0)
                        r.status = ST_NO_FREE;
                    else
                    begin
                        id        = free_ids[free_head];
                        free_head = (free_head + 1) % NUM_SEMS;
                        free_fill--;
                        wait_head[id] = 0;
                        wait_fill[id] = 0;
                        sem_count[id] = init[COUNT_BITS-1:0];
                        r.new_id      = NEWID_W'(id);
                    end
                end
                CMD_LOCK:
                begin
                    if (sem_count[sid] != 0)
                        sem_count[sid] = sem_count[sid] - 1'b1;
                    else if (wait_fill[sid] >= NUM_PROCS)
                        r.status = ST_QFULL;
                    else
                    begin
                        slot = (wait_head[sid] + wait_fill[sid]) % NUM_PROCS;
                        waiters[sid][slot] = pid;
                        wait_fill[sid]++;
                        r.status = ST_SUSPENDED;
                    end
                end
                CMD_UNLOCK:
                begin
                    if (wait_fill[sid] == 0)
                    begin
                        if (sem_count[sid] != COUNT_MAX)
                            sem_count[sid] = sem_count[sid] + 1'b1;
                    end
                    else
                    begin
                        r.released_pid = waiters[sid][wait_head[sid]];
                        wait_head[sid] = (wait_head[sid] + 1) % NUM_PROCS;
                        wait_fill[sid]--;
                        r.status = ST_RELEASED;
                    end
                end
                default: ;
            endcase
            pending_answers.push_back(r);
        endfunction

        // Compare one result transaction against the oldest pending answer
        function void check_result(sem_result_t got);
            sem_result_t want;
            if (pending_answers.size() == 0)
            begin
                $error("result with no call pending: status %0d new_id %0d released_pid %0d",
                       got.status, got.new_id, got.released_pid);
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            checked++;
            status_seen[int'(want.status)]++;
            if (got.status !== want.status)
            begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.new_id !== want.new_id)
            begin
                $error("new_id expected %0d actual %0d", want.new_id, got.new_id);
                errors++;
            end
            if (got.released_pid !== want.released_pid)
            begin
                $error("released_pid expected %0d actual %0d",
                       want.released_pid, got.released_pid);
                errors++;
            end
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    logic [CMD_W-1:0]        s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic [STATUS_W-1:0]     m_axis_tuser;

    sem_scoreboard sb;
    int            cycle_count;
    bit            quiet;
    int            rx_stall;

    counting_semaphore_engine_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Idle length: mostly none, some short, a few long; none in quiet stretches
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: random back-pressure, changed on the falling edge
    initial
    begin
        m_axis_tready = 1'b0;
        rx_stall      = 0;
        forever
        begin
            @(negedge clk);
            if (rx_stall > 0)
            begin
                m_axis_tready = 1'b0;
                rx_stall--;
            end
            else
            begin
                m_axis_tready = 1'b1;
                rx_stall      = pick_gap();
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result('{status_t'(m_axis_tuser), m_axis_tdata[3:0], m_axis_tdata[8:4]});
    end

    // Drive one call; returns right after the edge that accepts it
    task automatic send_call(logic [CMD_W-1:0] cmd, logic [SID_W-1:0] sid,
                             logic [PID_W-1:0] pid, logic [INIT_W-1:0] init);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {7'b0, init, pid, sid};
        s_axis_tuser  = cmd;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_call(cmd, sid, pid, init);
    endtask

    // Hold the sender off until every pending answer has come back
    task automatic wait_for_answers();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending_answers.size() != 0) @(negedge clk);
    endtask

    // Random call, biased toward a few semaphores so queues build up
    task automatic random_call();
        int                 r;
        logic [CMD_W-1:0]   cmd;
        logic [SID_W-1:0]   sid;
        logic [INIT_W-1:0]  init;
        r = $urandom_range(0, 99);
        if (r < 3)
            cmd = CMD_CREATE;
        else if (r < 5)
            cmd = CMD_UNUSED;
        else if (r < 52)
            cmd = CMD_LOCK;
        else
            cmd = CMD_UNLOCK;
        if ($urandom_range(0, 3) == 0)
            sid = SID_W'($urandom_range(0, NUM_SEMS - 1));
        else
            sid = SID_W'($urandom_range(0, 3));
        case ($urandom_range(0, 5))
            0:       init = '0;
            1:       init = INIT_W'($urandom_range(1, 3));
            2:       init = '1;
            default: init = INIT_W'($urandom_range(0, 255));
        endcase
        send_call(cmd, sid, PID_W'($urandom_range(0, NUM_PROCS - 1)), init);
    endtask

    task automatic lock_burst(logic [SID_W-1:0] sid, int n);
        repeat (n) send_call(CMD_LOCK, sid, PID_W'($urandom_range(0, NUM_PROCS - 1)), '0);
    endtask

    task automatic unlock_burst(logic [SID_W-1:0] sid, int n);
        repeat (n) send_call(CMD_UNLOCK, sid, PID_W'($urandom_range(0, NUM_PROCS - 1)), '0);
    endtask

    // Main sequence
    initial
    begin
        int               victim;
        logic [SID_W-1:0] vsid;
        sb            = new();
        quiet         = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_CREATE;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: saturation, suspend and release order, unused command,
        // a semaphore that was never created
        send_call(CMD_CREATE, 4'd0, 5'd0, 8'hFF);
        send_call(CMD_UNLOCK, 4'd0, 5'd0, 8'h00);
        send_call(CMD_LOCK,   4'd0, 5'd0, 8'h00);
        send_call(CMD_CREATE, 4'd9, 5'd31, 8'h00);
        send_call(CMD_LOCK,   4'd1, 5'd0, 8'h00);
        send_call(CMD_LOCK,   4'd1, 5'd31, 8'h00);
        send_call(CMD_LOCK,   4'd1, 5'd21, 8'h00);
        send_call(CMD_UNLOCK, 4'd1, 5'd3, 8'h00);
        send_call(CMD_UNLOCK, 4'd1, 5'd3, 8'h00);
        send_call(CMD_UNLOCK, 4'd1, 5'd3, 8'h00);
        send_call(CMD_UNLOCK, 4'd1, 5'd3, 8'h00);
        send_call(CMD_LOCK,   4'd1, 5'd10, 8'h00);
        send_call(CMD_UNUSED, 4'd15, 5'd31, 8'hFF);
        send_call(CMD_LOCK,   4'd15, 5'd31, 8'h00);
        send_call(CMD_UNLOCK, 4'd15, 5'd0, 8'h00);
        send_call(CMD_CREATE, 4'd0, 5'd0, 8'hAA);
        send_call(CMD_CREATE, 4'd0, 5'd0, 8'h55);
        send_call(CMD_UNLOCK, 4'd15, 5'd0, 8'h00);
        send_call(CMD_LOCK,   4'd0, 5'd31, 8'h00);
        wait_for_answers();

        // Random mix; creates run the free list dry along the way
        for (int i = 0; i < 500; i++)
        begin
            if (i % 100 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            random_call();
        end
        wait_for_answers();

        // Fill the wait queue of the least loaded semaphore past its depth,
        // drain part of it, refill across the wrap point, then empty it
        victim = 0;
        for (int s = 1; s < NUM_SEMS; s++)
            if (sb.sem_count[s] < sb.sem_count[victim])
                victim = s;
        vsid  = SID_W'(victim);
        quiet = 1'b0;
        lock_burst(vsid, int'(sb.sem_count[victim]) + NUM_PROCS - sb.wait_fill[victim] + 3);
        unlock_burst(vsid, 13);
        quiet = 1'b1;
        lock_burst(vsid, 16);
        unlock_burst(vsid, NUM_PROCS + 8);
        wait_for_answers();

        // Second random stretch, opening without idling
        for (int i = 0; i < 600; i++)
        begin
            if (i % 100 == 0)
                quiet = (i == 0) || ($urandom_range(0, 2) == 0);
            random_call();
        end
        quiet = 1'b0;
        wait_for_answers();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d calls sent, %0d results checked", sb.calls, sb.checked);
        $display("suspended %0d, released %0d, no free id %0d, queue full %0d",
                 sb.status_seen[ST_SUSPENDED], sb.status_seen[ST_RELEASED],
                 sb.status_seen[ST_NO_FREE], sb.status_seen[ST_QFULL]);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
